// ===== rtl/imts_pkg.sv =====
// Shared types, constants and the arctangent table for the IMU tilt unit.
package imts_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int FRAC_W     = 16;
    localparam int AVG_W      = SAMPLE_W + FRAC_W;
    localparam int SCALE_SH   = (AVG_W > 31) ? AVG_W - 31 : 0;
    localparam int OP_W       = AVG_W - SCALE_SH;
    localparam int SQ_W       = 2 * OP_W;
    localparam int ROOT_W     = OP_W;
    localparam int CORD_W     = OP_W + 5;
    localparam int ANG_W      = 32;
    localparam int ATAN_W     = 22;
    localparam int CNT_W      = 5;
    localparam int IDX_W      = 3;
    localparam int ALPHA_W    = 17;
    localparam int THR_W      = 18;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 18;
    localparam int SQRT_STEPS = ROOT_W;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'h10000;
    localparam logic signed [15:0] ANGLE_LIMIT = 16'sd23040;

    localparam logic [CFG_IDX_W-1:0] REG_SENSOR_ALPHA  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_READOUT_ALPHA = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACT_THRESHOLD = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REPORT_SEL    = 8'd3;

    localparam logic [2:0] ORIENT_FACE_UP   = 3'd0;
    localparam logic [2:0] ORIENT_FACE_DOWN = 3'd1;
    localparam logic [2:0] ORIENT_LEFT_UP   = 3'd2;
    localparam logic [2:0] ORIENT_RIGHT_UP  = 3'd3;
    localparam logic [2:0] ORIENT_BOTTOM_UP = 3'd4;
    localparam logic [2:0] ORIENT_TOP_UP    = 3'd5;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] raw_accel_x;
        logic signed [SAMPLE_W-1:0] raw_accel_y;
        logic signed [SAMPLE_W-1:0] raw_accel_z;
        logic signed [SAMPLE_W-1:0] raw_gyro_x;
        logic signed [SAMPLE_W-1:0] raw_gyro_y;
        logic signed [SAMPLE_W-1:0] raw_gyro_z;
    } in_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] accel_x;
        logic signed [SAMPLE_W-1:0] accel_y;
        logic signed [SAMPLE_W-1:0] accel_z;
        logic signed [SAMPLE_W-1:0] gyro_x;
        logic signed [SAMPLE_W-1:0] gyro_y;
        logic signed [SAMPLE_W-1:0] gyro_z;
        logic signed [15:0]         pitch;
        logic signed [15:0]         roll;
        logic [2:0]                 orientation;
        logic                       activity;
    } out_t;

    typedef struct packed {
        logic [ALPHA_W-1:0] sensor_alpha;
        logic [ALPHA_W-1:0] readout_alpha;
        logic [THR_W-1:0]   activity_threshold;
        logic               report_readout;
    } cfg_t;

    typedef struct packed {
        logic             load_in;
        logic             sblend;
        logic             sq_first;
        logic             sq_second;
        logic             sqrt_step;
        logic             pitch_set;
        logic             roll_set;
        logic             cord_step;
        logic             save_pitch;
        logic             save_roll;
        logic             rblend;
        logic             out_load;
        logic [IDX_W-1:0] idx;
        logic [CNT_W-1:0] iter;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } stat_t;

    // atan(2^-i) in 1/65536 degree
    function automatic logic [ATAN_W-1:0] atan_lut(input logic [CNT_W-1:0] i);
        logic [ATAN_W-1:0] r;
        case (i)
            5'd0:    r = 22'd2949120;
            5'd1:    r = 22'd1740967;
            5'd2:    r = 22'd919879;
            5'd3:    r = 22'd466945;
            5'd4:    r = 22'd234378;
            5'd5:    r = 22'd117304;
            5'd6:    r = 22'd58666;
            5'd7:    r = 22'd29335;
            5'd8:    r = 22'd14668;
            5'd9:    r = 22'd7334;
            5'd10:   r = 22'd3667;
            5'd11:   r = 22'd1833;
            5'd12:   r = 22'd917;
            5'd13:   r = 22'd458;
            5'd14:   r = 22'd229;
            5'd15:   r = 22'd115;
            5'd16:   r = 22'd57;
            5'd17:   r = 22'd29;
            5'd18:   r = 22'd14;
            5'd19:   r = 22'd7;
            5'd20:   r = 22'd4;
            5'd21:   r = 22'd2;
            5'd22:   r = 22'd1;
            default: r = 22'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/imu_tilt_smoothing_activity_unit.sv =====
// Top level of the IMU tilt, smoothing and activity unit.
//
//  channel   direction  handshake            payload
//  in        sink       in_valid/in_ready    in_data (in_t, six raw counts)
//  out       source     out_valid/out_ready  out_data (out_t, averages, angles, flags)
//  cfg       sink       cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  Between accept and result a sample runs through the 31-step bit-serial root and the
//  two shared CORDIC passes.
//  A new sample is taken once the previous one has finished, in the cycle after the load;
//  the result waits in the output register, and only a full output register with
//  out_ready low stalls.
//  Reset clears all averages and the seen and valid flags and loads the register defaults.
module imu_tilt_smoothing_activity_unit
    import imts_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_t                   in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_t                  out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t  cfg_reg;
    cmd_t  cmd;
    stat_t stat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sensor_alpha       <= 17'd16384;
            cfg_reg.readout_alpha      <= 17'd8192;
            cfg_reg.activity_threshold <= 18'd820;
            cfg_reg.report_readout     <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_SENSOR_ALPHA:  cfg_reg.sensor_alpha       <= cfg_data[ALPHA_W-1:0];
                REG_READOUT_ALPHA: cfg_reg.readout_alpha      <= cfg_data[ALPHA_W-1:0];
                REG_ACT_THRESHOLD: cfg_reg.activity_threshold <= cfg_data[THR_W-1:0];
                REG_REPORT_SEL:    cfg_reg.report_readout     <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    imts_ctrl #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    imts_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg       (cfg_reg),
        .in_data   (in_data),
        .stat      (stat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// ===== rtl/imts_ctrl.sv =====
// Sequencer for the IMU tilt unit: steps the datapath through one sample.
module imts_ctrl
    import imts_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    typedef enum logic [10:0] {
        S_IDLE   = 11'b000_0000_0001,
        S_SBLEND = 11'b000_0000_0010,
        S_SQ1    = 11'b000_0000_0100,
        S_SQ2    = 11'b000_0000_1000,
        S_SQRT   = 11'b000_0001_0000,
        S_PSET   = 11'b000_0010_0000,
        S_PITER  = 11'b000_0100_0000,
        S_RSET   = 11'b000_1000_0000,
        S_RITER  = 11'b001_0000_0000,
        S_RBLEND = 11'b010_0000_0000,
        S_LOAD   = 11'b100_0000_0000
    } state_t;

    localparam logic [CNT_W-1:0] LAST_CORD = CNT_W'(CORDIC_STEPS - 1);
    localparam logic [CNT_W-1:0] LAST_SQRT = CNT_W'(SQRT_STEPS - 1);
    localparam logic [CNT_W-1:0] LAST_SCH  = CNT_W'(5);
    localparam logic [CNT_W-1:0] LAST_RCH  = CNT_W'(7);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.idx    = cnt_reg[IDX_W-1:0];
        cmd.iter   = cnt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    cnt_next    = '0;
                    state_next  = S_SBLEND;
                end
            end
            S_SBLEND:
            begin
                cmd.sblend = 1'b1;
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == LAST_SCH)
                begin
                    state_next = S_SQ1;
                end
            end
            S_SQ1:
            begin
                cmd.sq_first = 1'b1;
                state_next   = S_SQ2;
            end
            S_SQ2:
            begin
                cmd.sq_second = 1'b1;
                cnt_next      = '0;
                state_next    = S_SQRT;
            end
            S_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == LAST_SQRT)
                begin
                    state_next = S_PSET;
                end
            end
            S_PSET:
            begin
                cmd.pitch_set = 1'b1;
                cnt_next      = '0;
                state_next    = S_PITER;
            end
            S_PITER:
            begin
                cmd.cord_step = 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == LAST_CORD)
                begin
                    state_next = S_RSET;
                end
            end
            S_RSET:
            begin
                cmd.save_pitch = 1'b1;
                cmd.roll_set   = 1'b1;
                cnt_next       = '0;
                state_next     = S_RITER;
            end
            S_RITER:
            begin
                cmd.cord_step = 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == LAST_CORD)
                begin
                    cnt_next   = '0;
                    state_next = S_RBLEND;
                end
            end
            S_RBLEND:
            begin
                cmd.rblend    = 1'b1;
                cmd.save_roll = (cnt_reg == '0);
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == LAST_RCH)
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_in |=> !in_ready)
        else $error("sequencer stayed idle after taking a sample");

    a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> stat.out_free)
        else $error("result loaded over an untaken beat");

    a_roll_saved_first_blend: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.save_roll |-> $past(cmd.cord_step))
        else $error("roll saved before its rotation finished");

endmodule

// ===== rtl/imts_dp.sv =====
// Datapath of the IMU tilt unit: averages, root, CORDIC, orientation, activity.
module imts_dp
    import imts_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  cmd_t  cmd,
    input  cfg_t  cfg,
    input  in_t   in_data,
    output stat_t stat,
    output logic  out_valid,
    input  logic  out_ready,
    output out_t  out_data
);

    logic signed [SAMPLE_W-1:0] mapped_reg [6];
    logic signed [SAMPLE_W-1:0] prev_reg [3];
    logic                       prev_seen_reg;
    logic                       act_reg;
    logic                       sseen_reg;
    logic                       rseen_reg;
    logic signed [AVG_W-1:0]    savg_reg [6];
    logic signed [AVG_W-1:0]    ravg_reg [8];
    logic [SQ_W-1:0]            sqv_reg;
    logic [SQ_W-1:0]            sqres_reg;
    logic [SQ_W-1:0]            sqbit_reg;
    logic signed [CORD_W-1:0]   cx_reg;
    logic signed [CORD_W-1:0]   cy_reg;
    logic signed [ANG_W-1:0]    cz_reg;
    logic                       czero_reg;
    logic signed [15:0]         pitch_reg;
    logic signed [15:0]         roll_reg;
    logic                       out_valid_reg;
    out_t                       out_reg;

    assign out_valid     = out_valid_reg;
    assign out_data      = out_reg;
    assign stat.out_free = !out_valid_reg || out_ready;

    // ---- input mapping and activity ----
    function automatic logic signed [SAMPLE_W-1:0] sat_neg(input logic signed [SAMPLE_W-1:0] v);
        logic signed [SAMPLE_W-1:0] r;
        if (v == {1'b1, {(SAMPLE_W-1){1'b0}}})
        begin
            r = {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
        else
        begin
            r = -v;
        end
        return r;
    endfunction

    function automatic logic [SAMPLE_W:0] abs_diff(input logic signed [SAMPLE_W-1:0] a,
                                                   input logic signed [SAMPLE_W-1:0] b);
        logic signed [SAMPLE_W:0] d;
        d = $signed({a[SAMPLE_W-1], a}) - $signed({b[SAMPLE_W-1], b});
        return d[SAMPLE_W] ? (SAMPLE_W+1)'(-d) : d;
    endfunction

    logic [SAMPLE_W+2:0] delta;
    logic                act_next;

    always_comb
    begin
        delta = (SAMPLE_W+3)'(abs_diff(in_data.raw_accel_x, prev_reg[0]))
              + (SAMPLE_W+3)'(abs_diff(in_data.raw_accel_y, prev_reg[1]))
              + (SAMPLE_W+3)'(abs_diff(in_data.raw_accel_z, prev_reg[2]));
        act_next = prev_seen_reg && (delta >= (SAMPLE_W+3)'(cfg.activity_threshold));
    end

    // ---- shared blend unit ----
    logic signed [AVG_W-1:0]   b_cur, b_tgt, b_res;
    logic [ALPHA_W-1:0]        b_alpha, b_a;
    logic                      b_seen;
    logic signed [AVG_W:0]     b_diff;
    logic signed [AVG_W+18:0]  b_prod;
    logic signed [AVG_W+2:0]   b_sum;

    always_comb
    begin
        if (cmd.rblend)
        begin
            b_cur   = ravg_reg[cmd.idx];
            b_alpha = cfg.readout_alpha;
            b_seen  = rseen_reg;
            case (cmd.idx)
                3'd6:    b_tgt = {pitch_reg, {FRAC_W{1'b0}}};
                3'd7:    b_tgt = {roll_reg, {FRAC_W{1'b0}}};
                default: b_tgt = savg_reg[cmd.idx];
            endcase
        end
        else
        begin
            b_cur   = savg_reg[cmd.idx];
            b_alpha = cfg.sensor_alpha;
            b_seen  = sseen_reg;
            b_tgt   = {mapped_reg[cmd.idx], {FRAC_W{1'b0}}};
        end
        b_a    = (b_alpha > ALPHA_ONE) ? ALPHA_ONE : b_alpha;
        b_diff = $signed({b_tgt[AVG_W-1], b_tgt}) - $signed({b_cur[AVG_W-1], b_cur});
        b_prod = b_diff * $signed({1'b0, b_a});
        b_sum  = $signed({{3{b_cur[AVG_W-1]}}, b_cur}) + b_prod[AVG_W+18:16];
        b_res  = b_seen ? b_sum[AVG_W-1:0] : b_tgt;
    end

    // ---- squares and root ----
    logic signed [OP_W-1:0] sc0, sc1, sc2, sq_in;
    logic [OP_W-1:0]        sq_mag;
    logic [SQ_W-1:0]        sq_prod, sq_trial;
    logic                   sq_ge;

    always_comb
    begin
        sc0      = savg_reg[0][AVG_W-1:SCALE_SH];
        sc1      = savg_reg[1][AVG_W-1:SCALE_SH];
        sc2      = savg_reg[2][AVG_W-1:SCALE_SH];
        sq_in    = cmd.sq_second ? sc2 : sc1;
        sq_mag   = sq_in[OP_W-1] ? OP_W'(-sq_in) : sq_in;
        sq_prod  = {{OP_W{1'b0}}, sq_mag} * {{OP_W{1'b0}}, sq_mag};
        sq_trial = sqres_reg + sqbit_reg;
        sq_ge    = sqv_reg >= sq_trial;
    end

    // ---- CORDIC ----
    logic signed [CORD_W-1:0] cs_x, cs_y, cs_x0, cs_y0, c_dx, c_dy;
    logic signed [ANG_W-1:0]  cs_z, c_at;
    logic                     cs_zero;
    logic signed [ANG_W-1:0]  z_rnd;
    logic signed [ANG_W-10:0] z_ang;
    logic signed [15:0]       ang_out;

    always_comb
    begin
        if (cmd.roll_set)
        begin
            cs_y0 = CORD_W'(sc1);
            cs_x0 = CORD_W'(sc2);
        end
        else
        begin
            cs_y0 = -CORD_W'(sc0);
            cs_x0 = $signed({{(CORD_W-ROOT_W){1'b0}}, sqres_reg[ROOT_W-1:0]});
        end
        cs_zero = (cs_x0 == '0) && (cs_y0 == '0);
        cs_x    = cs_x0;
        cs_y    = cs_y0;
        cs_z    = '0;
        if (cs_x0 < 0)
        begin
            if (cs_y0 >= 0)
            begin
                cs_x = cs_y0;
                cs_y = -cs_x0;
                cs_z = ANG_W'(90 * 65536);
            end
            else
            begin
                cs_x = -cs_y0;
                cs_y = cs_x0;
                cs_z = -ANG_W'(90 * 65536);
            end
        end
        c_dx = cy_reg >>> cmd.iter;
        c_dy = cx_reg >>> cmd.iter;
        c_at = $signed({{(ANG_W-ATAN_W){1'b0}}, atan_lut(cmd.iter)});
        // round half up to 1/128 degree, then clamp
        z_rnd = cz_reg + ANG_W'(256);
        z_ang = z_rnd[ANG_W-1:9];
        if (czero_reg)
        begin
            ang_out = '0;
        end
        else if (z_ang > (ANG_W-9)'(ANGLE_LIMIT))
        begin
            ang_out = ANGLE_LIMIT;
        end
        else if (z_ang < -(ANG_W-9)'(ANGLE_LIMIT))
        begin
            ang_out = -ANGLE_LIMIT;
        end
        else
        begin
            ang_out = z_ang[15:0];
        end
    end

    // ---- orientation and result ----
    logic [AVG_W-1:0] ax, ay, az;
    logic [2:0]       orient;
    out_t             res;

    always_comb
    begin
        ax = savg_reg[0][AVG_W-1] ? AVG_W'(-savg_reg[0]) : savg_reg[0];
        ay = savg_reg[1][AVG_W-1] ? AVG_W'(-savg_reg[1]) : savg_reg[1];
        az = savg_reg[2][AVG_W-1] ? AVG_W'(-savg_reg[2]) : savg_reg[2];
        if (az >= ax && az >= ay)
        begin
            orient = savg_reg[2][AVG_W-1] ? ORIENT_FACE_DOWN : ORIENT_FACE_UP;
        end
        else if (ax >= ay)
        begin
            orient = savg_reg[0][AVG_W-1] ? ORIENT_RIGHT_UP : ORIENT_LEFT_UP;
        end
        else
        begin
            orient = savg_reg[1][AVG_W-1] ? ORIENT_TOP_UP : ORIENT_BOTTOM_UP;
        end
        if (cfg.report_readout)
        begin
            res.accel_x = ravg_reg[0][AVG_W-1:FRAC_W];
            res.accel_y = ravg_reg[1][AVG_W-1:FRAC_W];
            res.accel_z = ravg_reg[2][AVG_W-1:FRAC_W];
            res.gyro_x  = ravg_reg[3][AVG_W-1:FRAC_W];
            res.gyro_y  = ravg_reg[4][AVG_W-1:FRAC_W];
            res.gyro_z  = ravg_reg[5][AVG_W-1:FRAC_W];
            res.pitch   = ravg_reg[6][AVG_W-1:FRAC_W];
            res.roll    = ravg_reg[7][AVG_W-1:FRAC_W];
        end
        else
        begin
            res.accel_x = savg_reg[0][AVG_W-1:FRAC_W];
            res.accel_y = savg_reg[1][AVG_W-1:FRAC_W];
            res.accel_z = savg_reg[2][AVG_W-1:FRAC_W];
            res.gyro_x  = savg_reg[3][AVG_W-1:FRAC_W];
            res.gyro_y  = savg_reg[4][AVG_W-1:FRAC_W];
            res.gyro_z  = savg_reg[5][AVG_W-1:FRAC_W];
            res.pitch   = pitch_reg;
            res.roll    = roll_reg;
        end
        res.orientation = orient;
        res.activity    = act_reg;
    end

    // ---- control state ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_seen_reg <= 1'b0;
            sseen_reg     <= 1'b0;
            rseen_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_in)
            begin
                prev_seen_reg <= 1'b1;
            end
            if (cmd.sq_first)
            begin
                sseen_reg <= 1'b1;
            end
            if (cmd.out_load)
            begin
                rseen_reg     <= 1'b1;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // averages and previous sample hold the zero reset state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                savg_reg[i] <= '0;
            end
            for (int i = 0; i < 8; i++)
            begin
                ravg_reg[i] <= '0;
            end
            for (int i = 0; i < 3; i++)
            begin
                prev_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.sblend)
            begin
                savg_reg[cmd.idx] <= b_res;
            end
            if (cmd.rblend)
            begin
                ravg_reg[cmd.idx] <= b_res;
            end
            if (cmd.load_in)
            begin
                prev_reg[0] <= in_data.raw_accel_x;
                prev_reg[1] <= in_data.raw_accel_y;
                prev_reg[2] <= in_data.raw_accel_z;
            end
        end
    end

    // ---- payload ----
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            mapped_reg[0] <= sat_neg(in_data.raw_accel_y);
            mapped_reg[1] <= sat_neg(in_data.raw_accel_x);
            mapped_reg[2] <= sat_neg(in_data.raw_accel_z);
            mapped_reg[3] <= sat_neg(in_data.raw_gyro_y);
            mapped_reg[4] <= sat_neg(in_data.raw_gyro_x);
            mapped_reg[5] <= sat_neg(in_data.raw_gyro_z);
            act_reg       <= act_next;
        end
        if (cmd.sq_first)
        begin
            sqv_reg <= sq_prod;
        end
        if (cmd.sq_second)
        begin
            sqv_reg   <= sqv_reg + sq_prod;
            sqres_reg <= '0;
            sqbit_reg <= SQ_W'(1) << (SQ_W - 2);
        end
        if (cmd.sqrt_step)
        begin
            if (sq_ge)
            begin
                sqv_reg   <= sqv_reg - sq_trial;
                sqres_reg <= (sqres_reg >> 1) + sqbit_reg;
            end
            else
            begin
                sqres_reg <= sqres_reg >> 1;
            end
            sqbit_reg <= sqbit_reg >> 2;
        end
        if (cmd.pitch_set || cmd.roll_set)
        begin
            cx_reg    <= cs_x;
            cy_reg    <= cs_y;
            cz_reg    <= cs_z;
            czero_reg <= cs_zero;
        end
        if (cmd.cord_step)
        begin
            if (cy_reg > 0)
            begin
                cx_reg <= cx_reg + c_dx;
                cy_reg <= cy_reg - c_dy;
                cz_reg <= cz_reg + c_at;
            end
            else
            begin
                cx_reg <= cx_reg - c_dx;
                cy_reg <= cy_reg + c_dy;
                cz_reg <= cz_reg - c_at;
            end
        end
        if (cmd.save_pitch)
        begin
            pitch_reg <= ang_out;
        end
        if (cmd.save_roll)
        begin
            roll_reg <= ang_out;
        end
        if (cmd.out_load)
        begin
            out_reg <= res;
        end
    end

    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid)
        else $error("result beat not raised after load");

    a_orient_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> (out_data.orientation != 3'd6 && out_data.orientation != 3'd7))
        else $error("orientation code out of range");

    a_angle_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.save_roll |=> (roll_reg <= ANGLE_LIMIT && roll_reg >= -ANGLE_LIMIT))
        else $error("roll angle escaped its clamp");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the IMU tilt, smoothing and activity unit.
`timescale 1ns / 100ps

module tb_top;
    import imts_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 120;
    localparam int RANDOM_ITEMS   = 1430;
    localparam int NUM_PHASES     = 6;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'd9;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    in_t                   in_data = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    out_t                  out_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    imu_tilt_smoothing_activity_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // shadow registers and state of the tilt pipeline
    longint m_sensor_alpha, m_readout_alpha, m_threshold;
    bit     m_report_readout;
    bit     m_sensor_seen, m_readout_seen, m_prev_seen;
    longint m_sensor_avg [6];
    longint m_readout_avg [8];
    longint m_prev_accel [3];

    out_t   pending_results [$];
    int     fail_count = 0;
    int     samples_sent = 0;
    int     results_seen = 0;
    int     idle_cycles = 0;
    bit     gaps_on = 1'b1;

    function automatic longint sat_negate(longint v);
        longint r;
        r = -v;
        return (r > 32767) ? 32767 : r;
    endfunction

    function automatic longint ema_update(longint cur, longint tgt, longint alpha);
        longint a;
        a = (alpha > 65536) ? 65536 : alpha;
        return cur + (((tgt - cur) * a) >>> 16);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic longint atan_deg(longint y, longint x);
        longint z, t, dx, dy;
        longint atan_step [16] = '{2949120, 1740967, 919879, 466945, 234378, 117304,
                                   58666, 29335, 14668, 7334, 3667, 1833, 917, 458,
                                   229, 115};
        z = 0;
        if (x == 0 && y == 0)
            return 0;
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y; y = -t; z = 90 * 65536;
            end
            else
            begin
                x = -y; y = t; z = -90 * 65536;
            end
        end
        for (int i = 0; i < 16; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0)
            begin
                x += dx; y -= dy; z += atan_step[i];
            end
            else
            begin
                x -= dx; y += dy; z -= atan_step[i];
            end
        end
        return z;
    endfunction

    function automatic longint to_angle_units(longint z);
        longint r;
        r = (z + 256) >>> 9;
        if (r > 23040) r = 23040;
        if (r < -23040) r = -23040;
        return r;
    endfunction

    function automatic longint abs64(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic out_t predict_tilt(in_t d);
        longint raw [6], mapped [6], scaled [3], fresh [8];
        longint pitch, roll, ax, ay, az, delta, root;
        logic [2:0] orient;
        bit act;
        out_t r;
        raw = '{d.raw_accel_x, d.raw_accel_y, d.raw_accel_z,
                d.raw_gyro_x, d.raw_gyro_y, d.raw_gyro_z};
        for (int i = 0; i < 2; i++)
        begin
            mapped[i*3]   = sat_negate(raw[i*3+1]);
            mapped[i*3+1] = sat_negate(raw[i*3]);
            mapped[i*3+2] = sat_negate(raw[i*3+2]);
        end
        for (int i = 0; i < 6; i++)
            m_sensor_avg[i] = m_sensor_seen ?
                ema_update(m_sensor_avg[i], mapped[i] * 65536, m_sensor_alpha) :
                mapped[i] * 65536;
        m_sensor_seen = 1'b1;

        for (int i = 0; i < 3; i++)
            scaled[i] = m_sensor_avg[i] >>> 1;
        root = longint'(int_sqrt(abs64(scaled[1]) * abs64(scaled[1]) +
                                 abs64(scaled[2]) * abs64(scaled[2])));
        pitch = to_angle_units(atan_deg(-scaled[0], root));
        roll  = to_angle_units(atan_deg(scaled[1], scaled[2]));

        ax = abs64(m_sensor_avg[0]);
        ay = abs64(m_sensor_avg[1]);
        az = abs64(m_sensor_avg[2]);
        if (az >= ax && az >= ay)
            orient = (m_sensor_avg[2] >= 0) ? ORIENT_FACE_UP : ORIENT_FACE_DOWN;
        else if (ax >= ay)
            orient = (m_sensor_avg[0] >= 0) ? ORIENT_LEFT_UP : ORIENT_RIGHT_UP;
        else
            orient = (m_sensor_avg[1] >= 0) ? ORIENT_BOTTOM_UP : ORIENT_TOP_UP;

        for (int i = 0; i < 6; i++)
            fresh[i] = m_sensor_avg[i];
        fresh[6] = pitch * 65536;
        fresh[7] = roll * 65536;
        for (int i = 0; i < 8; i++)
            m_readout_avg[i] = m_readout_seen ?
                ema_update(m_readout_avg[i], fresh[i], m_readout_alpha) : fresh[i];
        m_readout_seen = 1'b1;

        act = 1'b0;
        if (m_prev_seen)
        begin
            delta = 0;
            for (int i = 0; i < 3; i++)
                delta += abs64(raw[i] - m_prev_accel[i]);
            act = (delta >= m_threshold);
        end
        for (int i = 0; i < 3; i++)
            m_prev_accel[i] = raw[i];
        m_prev_seen = 1'b1;

        if (m_report_readout)
            fresh = m_readout_avg;
        r.accel_x = 16'(fresh[0] >>> 16);
        r.accel_y = 16'(fresh[1] >>> 16);
        r.accel_z = 16'(fresh[2] >>> 16);
        r.gyro_x  = 16'(fresh[3] >>> 16);
        r.gyro_y  = 16'(fresh[4] >>> 16);
        r.gyro_z  = 16'(fresh[5] >>> 16);
        r.pitch   = 16'(fresh[6] >>> 16);
        r.roll    = 16'(fresh[7] >>> 16);
        r.orientation = orient;
        r.activity = act;
        return r;
    endfunction

    function automatic in_t mk_sample(int ax, int ay, int az, int gx, int gy, int gz);
        in_t d;
        d.raw_accel_x = 16'(ax); d.raw_accel_y = 16'(ay); d.raw_accel_z = 16'(az);
        d.raw_gyro_x  = 16'(gx); d.raw_gyro_y  = 16'(gy); d.raw_gyro_z  = 16'(gz);
        return d;
    endfunction

    function automatic int pick_extreme();
        int v;
        case ($urandom_range(0, 3))
            0: v = -32768;
            1: v = 32767;
            2: v = 0;
            default: v = -1;
        endcase
        return v;
    endfunction

    function automatic in_t random_sample();
        int g [3];
        int k;
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 6)
        begin
            // gravity-like vector along one axis with noise, modest rates
            k = $urandom_range(0, 2);
            for (int i = 0; i < 3; i++)
                g[i] = $urandom_range(0, 1600) - 800;
            g[k] += ($urandom_range(0, 1) != 0) ? 8192 : -8192;
            return mk_sample(g[0], g[1], g[2], $urandom_range(0, 8000) - 4000,
                             $urandom_range(0, 8000) - 4000, $urandom_range(0, 8000) - 4000);
        end
        else if (sel < 9)
            return in_t'({$urandom, $urandom, $urandom});
        return mk_sample(pick_extreme(), pick_extreme(), pick_extreme(),
                         pick_extreme(), pick_extreme(), pick_extreme());
    endfunction

    // accept and check, both on the rising edge
    always @(posedge clk)
    begin
        out_t want;
        if (in_valid && in_ready)
        begin
            pending_results.push_back(predict_tilt(in_data));
            samples_sent++;
        end
        if (out_valid && out_ready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with nothing expected, actual %p", $realtime, out_data);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_data !== want)
                begin
                    $display("%0t: mismatch expected %p", $realtime, want);
                    $display("%0t:          actual   %p", $realtime, out_data);
                    fail_count++;
                end
            end
        end
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog, no beat for %0d cycles", $realtime, idle_cycles);
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // result side backpressure
    initial
    begin
        int stall;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = (gaps_on && $urandom_range(0, 2) != 0) ? $urandom_range(0, 14) : 0;
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
            @(negedge clk);
        end
    end

    // call and return on a falling edge
    task automatic send_sample(in_t d);
        int gap;
        gap = gaps_on ? $urandom_range(0, 14) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= d;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_SENSOR_ALPHA:  m_sensor_alpha  = value & 'h1FFFF;
            REG_READOUT_ALPHA: m_readout_alpha = value & 'h1FFFF;
            REG_ACT_THRESHOLD: m_threshold     = value & 'h3FFFF;
            REG_REPORT_SEL:    m_report_readout = value[0];
            default: ;
        endcase
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    typedef struct {
        in_t  sample;
        bit   has_typed;
        out_t typed;
    } stim_row_t;

    initial
    begin
        stim_row_t rows [$];
        stim_row_t row;
        static longint phase_cfg [NUM_PHASES][4] = '{
            '{65536, 65536, 0, 1},
            '{0, 0, 196605, 1},
            '{131071, 100000, 262143, 0},
            '{1, 65535, 1, 1},
            '{30000, 2000, 3000, 0},
            '{16384, 8192, 820, 1}
        };

        m_sensor_alpha = 16384;
        m_readout_alpha = 8192;
        m_threshold = 820;
        m_report_readout = 1'b0;
        m_sensor_seen = 0; m_readout_seen = 0; m_prev_seen = 0;
        m_sensor_avg = '{default: 0};
        m_readout_avg = '{default: 0};
        m_prev_accel = '{default: 0};

        // first sample after reset: zero in, zero out, z tie goes face up
        row.sample = '0; row.has_typed = 1'b1; row.typed = '0;
        row.typed.orientation = ORIENT_FACE_UP;
        rows.push_back(row);
        row.has_typed = 1'b0;
        row.sample = mk_sample(-32768, -32768, -32768, -32768, -32768, -32768);
        rows.push_back(row);
        row.sample = mk_sample(32767, 32767, 32767, 32767, 32767, 32767);
        rows.push_back(row);
        row.sample = mk_sample(0, 0, -8192, 100, -100, 0);      rows.push_back(row);
        row.sample = mk_sample(0, 0, 8192, 0, 0, 0);            rows.push_back(row);
        row.sample = mk_sample(0, 0, 30000, 0, 0, 0);           rows.push_back(row);
        row.sample = mk_sample(0, -30000, 0, 0, 0, 0);          rows.push_back(row);
        row.sample = mk_sample(0, 30000, 0, 0, 0, 0);           rows.push_back(row);
        row.sample = mk_sample(-30000, 0, 0, 0, 0, 0);          rows.push_back(row);
        row.sample = mk_sample(30000, 0, 0, 0, 0, 0);           rows.push_back(row);
        row.sample = mk_sample(8192, 8192, 8192, 0, 0, 0);      rows.push_back(row);
        row.sample = mk_sample(8192, 8192, 0, 0, 0, 0);         rows.push_back(row);
        row.sample = mk_sample(8192, 8192, 0, 0, 0, 0);         rows.push_back(row);
        row.sample = mk_sample(8600, 8192, 0, 0, 0, 0);         rows.push_back(row);
        row.sample = mk_sample(-32768, 32767, -32768, 32767, -32768, 32767);
        rows.push_back(row);
        row.sample = mk_sample(0, 0, 0, -1, 1, -1);             rows.push_back(row);

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (rows[i])
        begin
            send_sample(rows[i].sample);
            if (rows[i].has_typed)
            begin
                // typed value replaces the predicted one
                void'(pending_results.pop_back());
                pending_results.push_back(rows[i].typed);
            end
        end
        drain();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_reg(REG_SENSOR_ALPHA, phase_cfg[p][0]);
            write_reg(REG_READOUT_ALPHA, phase_cfg[p][1]);
            write_reg(REG_ACT_THRESHOLD, phase_cfg[p][2]);
            write_reg(REG_REPORT_SEL, phase_cfg[p][3]);
            write_reg(REG_UNUSED, $urandom_range(0, 262143));
            cfg_valid <= 1'b0;
            gaps_on = (p != 2);
            for (int n = 0; n < RANDOM_ITEMS / NUM_PHASES; n++)
                send_sample(random_sample());
            drain();
        end

        $display("tb_top: %0d samples sent, %0d results checked over %0d register settings",
                 samples_sent, results_seen, NUM_PHASES + 1);
        $display("tb_top: orientations, ties, saturation, alpha clamp and activity covered");
        if (fail_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
